[rtl/imhh_pkg.sv]
package imhh_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int SCORE_BITS  = 32;
    localparam int ID_W        = 7;
    localparam int OUT_POS_W   = 7;
    localparam int POS_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);

    typedef enum logic [2:0] {
        OP_INSERT     = 3'd0,
        OP_REMOVE_MIN = 3'd1,
        OP_RAISE      = 3'd2,
        OP_LOWER      = 3'd3,
        OP_FIND       = 3'd4,
        OP_CROWN      = 3'd5,
        OP_LOCATE     = 3'd6
    } t_op;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_ABSENT  = 3'd1,
        STS_PRESENT = 3'd2,
        STS_FULL    = 3'd3,
        STS_EMPTY   = 3'd4,
        STS_BAD_ID  = 3'd5
    } t_status;

    typedef struct packed {
        logic [2:0]              operation;
        logic [ID_W-1:0]         entry_id;
        logic signed [31:0]      value;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]              status;
        logic [ID_W-1:0]         result_id;
        logic signed [31:0]      score;
        logic [OUT_POS_W-1:0]    location;
        logic [OUT_POS_W-1:0]    entry_count;
    } t_out_beat;

    typedef struct packed {
        logic [ID_W-1:0]             id;
        logic signed [SCORE_BITS-1:0] score;
    } t_entry;

    typedef struct packed {
        logic              heap_we;
        logic [ADDR_W-1:0] heap_waddr;
        t_entry            heap_wdata;
        logic [ADDR_W-1:0] heap_raddr;
        logic              hdl_we;
        logic [ADDR_W-1:0] hdl_waddr;
        logic [POS_W-1:0]  hdl_wdata;
        logic [ADDR_W-1:0] hdl_raddr;
    } t_mem_req;

    function automatic logic [ADDR_W-1:0] pos2addr(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] t;
        t = p - POS_W'(1);
        return t[ADDR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] id2addr(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] t;
        t = id - ID_W'(1);
        return t[ADDR_W-1:0];
    endfunction

endpackage

[rtl/imhh_store.sv]
module imhh_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  imhh_pkg::t_mem_req         i_req,
    output imhh_pkg::t_entry           o_heap_rd,
    output logic [imhh_pkg::POS_W-1:0] o_hdl_rd
);
    import imhh_pkg::*;

    t_entry                  r_heap [MAX_ENTRIES];
    logic [POS_W-1:0]        r_hdl  [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]  r_hv;
    t_entry                  r_heap_q;
    logic [POS_W-1:0]        r_hdl_q;
    logic                    r_hv_q;

    always_ff @(posedge i_clk) begin
        if (i_req.heap_we) begin
            r_heap[i_req.heap_waddr] <= i_req.heap_wdata;
        end
        r_heap_q <= r_heap[i_req.heap_raddr];
        if (i_req.hdl_we) begin
            r_hdl[i_req.hdl_waddr] <= i_req.hdl_wdata;
        end
        r_hdl_q <= r_hdl[i_req.hdl_raddr];
    end

    // A handle entry never written since reset reads as absent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv   <= '0;
            r_hv_q <= 1'b0;
        end else begin
            r_hv_q <= r_hv[i_req.hdl_raddr];
            if (i_req.hdl_we) begin
                r_hv[i_req.hdl_waddr] <= 1'b1;
            end
        end
    end

    assign o_heap_rd = r_heap_q;
    assign o_hdl_rd  = r_hv_q ? r_hdl_q : '0;

endmodule

[rtl/indexed_min_heap_with_handles.sv]
// Rejected and empty beats go straight to the result; lookups read the handle table and
// then the heap entry; inserts, raises and lowers go on with a sift-up or sift-down level
// by level, and crown repeats a removal for each entry dropped.
// One item at a time: the next beat is taken once the result is registered; each step is
// bound by one registered heap read and one heap write port with one shared comparator.
// Reset (synchronous, active low) empties the heap and marks every handle absent at once.
module indexed_min_heap_with_handles (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  imhh_pkg::t_in_beat  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output imhh_pkg::t_out_beat o_out
);
    import imhh_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_HRD, ST_HEAP, ST_SU_RD, ST_SU_CMP, ST_SU_W2,
        ST_SD_CHK, ST_SD_B, ST_SD_PICK, ST_SD_CMP, ST_SD_W2,
        ST_RM_TOP, ST_RM_LAST, ST_CR_FIN, ST_DONE
    } t_state;

    t_state             r_state;
    logic [2:0]         r_op;
    logic [ID_W-1:0]    r_id;
    logic signed [31:0] r_val;
    logic [POS_W-1:0]   r_cnt;
    logic [POS_W-1:0]   r_pos;
    logic [POS_W-1:0]   r_child;
    t_entry             r_a;
    t_entry             r_b;
    t_out_beat          r_res;
    t_out_beat          r_out;
    logic               r_ov;

    t_mem_req           mem_req;
    t_entry             heap_rd;
    logic [POS_W-1:0]   hdl_rd;

    logic signed [SCORE_BITS-1:0] cmp_x;
    logic signed [SCORE_BITS-1:0] cmp_y;
    logic                         cmp_gt;
    logic signed [SCORE_BITS-1:0] add_res;
    logic [POS_W:0]               child_w;
    logic [POS_W-1:0]             parent;
    logic                         sd_stop;
    logic                         fin;
    logic                         in_acc;
    logic                         id_ok;
    logic                         uses_id;

    imhh_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mem_req),
        .o_heap_rd(heap_rd),
        .o_hdl_rd (hdl_rd)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    assign id_ok   = (i_in.entry_id != '0) && (i_in.entry_id <= ID_W'(MAX_ENTRIES));
    assign uses_id = (i_in.operation == OP_INSERT) || (i_in.operation == OP_RAISE) ||
                     (i_in.operation == OP_LOWER) || (i_in.operation == OP_FIND) ||
                     (i_in.operation == OP_LOCATE);

    // Shared comparator and adder.
    always_comb begin
        case (r_state)
            ST_SU_CMP: begin
                cmp_x = heap_rd.score;
                cmp_y = r_a.score;
            end
            ST_SD_PICK: begin
                cmp_x = r_b.score;
                cmp_y = heap_rd.score;
            end
            default: begin
                cmp_x = r_a.score;
                cmp_y = r_b.score;
            end
        endcase
    end
    assign cmp_gt  = cmp_x > cmp_y;
    assign add_res = (r_op == OP_RAISE) ? (heap_rd.score + r_val) : (heap_rd.score - r_val);

    assign child_w = {r_pos, 1'b0};
    assign parent  = r_pos >> 1;
    assign sd_stop = (r_pos >= r_cnt) || (child_w > {1'b0, r_cnt});

    // The sift or removal in progress ends in this cycle.
    assign fin = ((r_state == ST_SU_RD) && (r_pos == POS_W'(1))) ||
                 ((r_state == ST_SU_CMP) && !cmp_gt) ||
                 ((r_state == ST_SD_CHK) && sd_stop) ||
                 ((r_state == ST_SD_CMP) && !cmp_gt) ||
                 ((r_state == ST_RM_TOP) && (r_cnt <= POS_W'(1)));

    always_comb begin
        mem_req = '0;
        case (r_state)
            ST_IDLE: begin
                mem_req.hdl_raddr = id2addr(i_in.entry_id);
            end
            ST_HRD: begin
                mem_req.heap_raddr = pos2addr(hdl_rd);
                if ((r_op == OP_INSERT) && (hdl_rd == '0)) begin
                    mem_req.heap_we    = 1'b1;
                    mem_req.heap_waddr = pos2addr(r_cnt + POS_W'(1));
                    mem_req.heap_wdata = '{id: r_id, score: r_val};
                    mem_req.hdl_we     = 1'b1;
                    mem_req.hdl_waddr  = id2addr(r_id);
                    mem_req.hdl_wdata  = r_cnt + POS_W'(1);
                end
            end
            ST_HEAP: begin
                if ((r_op == OP_RAISE) || (r_op == OP_LOWER)) begin
                    mem_req.heap_we    = 1'b1;
                    mem_req.heap_waddr = pos2addr(r_pos);
                    mem_req.heap_wdata = '{id: heap_rd.id, score: add_res};
                end
            end
            ST_SU_RD: begin
                if (r_pos != POS_W'(1)) begin
                    mem_req.heap_raddr = pos2addr(parent);
                end
            end
            ST_SU_CMP: begin
                if (cmp_gt) begin
                    mem_req.heap_we    = 1'b1;
                    mem_req.heap_waddr = pos2addr(r_pos);
                    mem_req.heap_wdata = heap_rd;
                    mem_req.hdl_we     = 1'b1;
                    mem_req.hdl_waddr  = id2addr(heap_rd.id);
                    mem_req.hdl_wdata  = r_pos;
                end
            end
            ST_SU_W2: begin
                mem_req.heap_we    = 1'b1;
                mem_req.heap_waddr = pos2addr(parent);
                mem_req.heap_wdata = r_a;
                mem_req.hdl_we     = 1'b1;
                mem_req.hdl_waddr  = id2addr(r_a.id);
                mem_req.hdl_wdata  = parent;
            end
            ST_SD_CHK: begin
                if (!sd_stop) begin
                    mem_req.heap_raddr = pos2addr(child_w[POS_W-1:0]);
                end
            end
            ST_SD_B: begin
                mem_req.heap_raddr = pos2addr(r_child + POS_W'(1));
            end
            ST_SD_CMP: begin
                if (cmp_gt) begin
                    mem_req.heap_we    = 1'b1;
                    mem_req.heap_waddr = pos2addr(r_pos);
                    mem_req.heap_wdata = r_b;
                    mem_req.hdl_we     = 1'b1;
                    mem_req.hdl_waddr  = id2addr(r_b.id);
                    mem_req.hdl_wdata  = r_pos;
                end
            end
            ST_SD_W2: begin
                mem_req.heap_we    = 1'b1;
                mem_req.heap_waddr = pos2addr(r_child);
                mem_req.heap_wdata = r_a;
                mem_req.hdl_we     = 1'b1;
                mem_req.hdl_waddr  = id2addr(r_a.id);
                mem_req.hdl_wdata  = r_child;
            end
            ST_RM_TOP: begin
                mem_req.hdl_we    = 1'b1;
                mem_req.hdl_waddr = id2addr(heap_rd.id);
                mem_req.hdl_wdata = '0;
                if (r_cnt > POS_W'(1)) begin
                    mem_req.heap_raddr = pos2addr(r_cnt);
                end
            end
            ST_RM_LAST: begin
                mem_req.heap_we    = 1'b1;
                mem_req.heap_waddr = pos2addr(POS_W'(1));
                mem_req.heap_wdata = heap_rd;
                mem_req.hdl_we     = 1'b1;
                mem_req.hdl_waddr  = id2addr(heap_rd.id);
                mem_req.hdl_wdata  = POS_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_op  <= i_in.operation;
                        r_id  <= i_in.entry_id;
                        r_val <= i_in.value;
                        r_res <= '0;
                        if (uses_id && !id_ok) begin
                            r_res.status    <= STS_BAD_ID;
                            r_res.result_id <= i_in.entry_id;
                            r_state         <= ST_DONE;
                        end else begin
                            case (i_in.operation)
                                OP_INSERT: begin
                                    if (r_cnt >= POS_W'(MAX_ENTRIES)) begin
                                        r_res.status    <= STS_FULL;
                                        r_res.result_id <= i_in.entry_id;
                                        r_state         <= ST_DONE;
                                    end else begin
                                        r_state <= ST_HRD;
                                    end
                                end
                                OP_RAISE, OP_LOWER, OP_FIND, OP_LOCATE: begin
                                    r_state <= ST_HRD;
                                end
                                OP_REMOVE_MIN, OP_CROWN: begin
                                    if (r_cnt == '0) begin
                                        r_res.status <= STS_EMPTY;
                                        r_state      <= ST_DONE;
                                    end else if ((i_in.operation == OP_CROWN) &&
                                                 (r_cnt == POS_W'(1))) begin
                                        r_state <= ST_CR_FIN;
                                    end else begin
                                        r_state <= ST_RM_TOP;
                                    end
                                end
                                default: begin
                                    r_state <= ST_DONE;
                                end
                            endcase
                        end
                    end
                end
                ST_HRD: begin
                    r_res.result_id <= r_id;
                    r_pos           <= hdl_rd;
                    if (r_op == OP_INSERT) begin
                        if (hdl_rd != '0) begin
                            r_res.status   <= STS_PRESENT;
                            r_state        <= ST_HEAP;
                        end else begin
                            r_cnt   <= r_cnt + POS_W'(1);
                            r_pos   <= r_cnt + POS_W'(1);
                            r_a     <= '{id: r_id, score: r_val};
                            r_state <= ST_SU_RD;
                        end
                    end else if (hdl_rd == '0) begin
                        r_res.status <= STS_ABSENT;
                        r_state      <= ST_DONE;
                    end else begin
                        r_state <= ST_HEAP;
                    end
                end
                ST_HEAP: begin
                    r_res.score    <= heap_rd.score;
                    r_res.location <= OUT_POS_W'(r_pos);
                    r_a            <= '{id: heap_rd.id, score: add_res};
                    case (r_op)
                        OP_RAISE: r_state <= ST_SD_CHK;
                        OP_LOWER: r_state <= ST_SU_RD;
                        default:  r_state <= ST_DONE;
                    endcase
                end
                ST_SU_RD: begin
                    r_state <= ST_SU_CMP;
                end
                ST_SU_CMP: begin
                    r_state <= ST_SU_W2;
                end
                ST_SU_W2: begin
                    r_pos   <= parent;
                    r_state <= ST_SU_RD;
                end
                ST_SD_CHK: begin
                    r_child <= child_w[POS_W-1:0];
                    r_state <= ST_SD_B;
                end
                ST_SD_B: begin
                    r_b     <= heap_rd;
                    r_state <= (r_child < r_cnt) ? ST_SD_PICK : ST_SD_CMP;
                end
                ST_SD_PICK: begin
                    // The right child wins only when strictly smaller.
                    if (cmp_gt) begin
                        r_b     <= heap_rd;
                        r_child <= r_child + POS_W'(1);
                    end
                    r_state <= ST_SD_CMP;
                end
                ST_SD_CMP: begin
                    r_state <= ST_SD_W2;
                end
                ST_SD_W2: begin
                    r_pos   <= r_child;
                    r_state <= ST_SD_CHK;
                end
                ST_RM_TOP: begin
                    if (r_op == OP_REMOVE_MIN) begin
                        r_res.status    <= STS_OK;
                        r_res.result_id <= heap_rd.id;
                        r_res.score     <= heap_rd.score;
                        r_res.location  <= '0;
                    end
                    if (r_cnt <= POS_W'(1)) begin
                        r_cnt <= '0;
                    end
                    r_state <= ST_RM_LAST;
                end
                ST_RM_LAST: begin
                    r_a     <= heap_rd;
                    r_cnt   <= r_cnt - POS_W'(1);
                    r_pos   <= POS_W'(1);
                    r_state <= ST_SD_CHK;
                end
                ST_CR_FIN: begin
                    r_res.status    <= STS_OK;
                    r_res.result_id <= heap_rd.id;
                    r_res.score     <= heap_rd.score;
                    r_res.location  <= OUT_POS_W'(1);
                    r_state         <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_ov || !i_out_stall) begin
                        r_out             <= r_res;
                        r_out.entry_count <= OUT_POS_W'(r_cnt);
                        r_ov              <= 1'b1;
                        r_state           <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            if (fin) begin
                case (r_op)
                    OP_INSERT, OP_RAISE, OP_LOWER: begin
                        r_res.status    <= STS_OK;
                        r_res.result_id <= r_a.id;
                        r_res.score     <= r_a.score;
                        r_res.location  <= OUT_POS_W'(r_pos);
                        r_state         <= ST_DONE;
                    end
                    OP_CROWN: begin
                        r_state <= (r_cnt > POS_W'(1)) ? ST_RM_TOP : ST_CR_FIN;
                    end
                    default: begin
                        r_state <= ST_DONE;
                    end
                endcase
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= POS_W'(MAX_ENTRIES))
        else $error("entry count above capacity");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("block took a beat and did not go busy");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_ov && i_out_stall) |=> (r_state == ST_DONE))
        else $error("result overwrote a stalled output beat");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SU_RD || r_state == ST_SD_CHK || r_state == ST_SD_W2) |->
        (r_pos != '0))
        else $error("sift running at position zero");

endmodule

[dv/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import imhh_pkg::*;

    localparam int CYCLE_LIMIT = 10000000;
    localparam int N_RANDOM    = 760;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out;

    indexed_min_heap_with_handles u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out)
    );

    // Shadow copy of the heap, kept in step with each accepted input beat.
    logic [ID_W-1:0]       sh_ids [1:MAX_ENTRIES];
    logic signed [31:0]    sh_scores [1:MAX_ENTRIES];
    int                    sh_handle [0:127];
    int                    sh_count;

    t_out_beat pending_results[$];
    int        errors;
    int        cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic bit score_gt(int a, int b);
        return sh_scores[a] > sh_scores[b];
    endfunction

    function automatic void swap_pos(int a, int b);
        logic [ID_W-1:0]    ti;
        logic signed [31:0] ts;
        ti = sh_ids[a];
        ts = sh_scores[a];
        sh_ids[a] = sh_ids[b];
        sh_scores[a] = sh_scores[b];
        sh_ids[b] = ti;
        sh_scores[b] = ts;
        sh_handle[sh_ids[a]] = a;
        sh_handle[sh_ids[b]] = b;
    endfunction

    function automatic void sink(int pos);
        int cur;
        int child;
        cur = pos;
        while (cur < sh_count) begin
            child = 2 * cur;
            if (child + 1 <= sh_count && score_gt(child, child + 1))
                child++;
            if (child <= sh_count && score_gt(cur, child)) begin
                swap_pos(cur, child);
                cur = child;
            end else begin
                break;
            end
        end
    endfunction

    function automatic void rise(int pos);
        int cur;
        cur = pos;
        while (cur > 1 && score_gt(cur / 2, cur)) begin
            swap_pos(cur / 2, cur);
            cur = cur / 2;
        end
    endfunction

    function automatic void pop_top();
        sh_handle[sh_ids[1]] = 0;
        if (sh_count > 1) begin
            sh_ids[1] = sh_ids[sh_count];
            sh_scores[1] = sh_scores[sh_count];
            sh_handle[sh_ids[1]] = 1;
        end
        sh_count--;
        sink(1);
    endfunction

    function automatic t_out_beat predict_heap_op(t_in_beat b);
        t_out_beat r;
        int        id;
        int        p;
        bit        uses_id;
        r = '0;
        id = b.entry_id;
        uses_id = b.operation inside {OP_INSERT, OP_RAISE, OP_LOWER, OP_FIND, OP_LOCATE};
        if (uses_id && (id < 1 || id > MAX_ENTRIES)) begin
            r.status = STS_BAD_ID;
            r.result_id = b.entry_id;
        end else if (b.operation == OP_INSERT) begin
            r.result_id = b.entry_id;
            if (sh_count >= MAX_ENTRIES) begin
                r.status = STS_FULL;
            end else if (sh_handle[id] != 0) begin
                r.status = STS_PRESENT;
                r.location = OUT_POS_W'(sh_handle[id]);
                r.score = sh_scores[sh_handle[id]];
            end else begin
                sh_count++;
                sh_ids[sh_count] = b.entry_id;
                sh_scores[sh_count] = b.value;
                sh_handle[id] = sh_count;
                rise(sh_count);
                r.location = OUT_POS_W'(sh_handle[id]);
                r.score = sh_scores[sh_handle[id]];
            end
        end else if (b.operation == OP_REMOVE_MIN) begin
            if (sh_count == 0) begin
                r.status = STS_EMPTY;
            end else begin
                r.result_id = sh_ids[1];
                r.score = sh_scores[1];
                pop_top();
            end
        end else if (uses_id) begin
            r.result_id = b.entry_id;
            if (sh_handle[id] == 0) begin
                r.status = STS_ABSENT;
            end else begin
                p = sh_handle[id];
                if (b.operation == OP_RAISE) begin
                    sh_scores[p] = sh_scores[p] + b.value;
                    sink(p);
                end else if (b.operation == OP_LOWER) begin
                    sh_scores[p] = sh_scores[p] - b.value;
                    rise(p);
                end
                r.location = OUT_POS_W'(sh_handle[id]);
                r.score = sh_scores[sh_handle[id]];
            end
        end else if (b.operation == OP_CROWN) begin
            if (sh_count == 0) begin
                r.status = STS_EMPTY;
            end else begin
                while (sh_count > 1)
                    pop_top();
                r.result_id = sh_ids[1];
                r.score = sh_scores[1];
                r.location = OUT_POS_W'(1);
            end
        end
        r.entry_count = OUT_POS_W'(sh_count);
        return r;
    endfunction

    // Gap length: mostly zero or short, now and then long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // Valid stays high from one beat into the next when there is no gap.
    task automatic send_beat(t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= b;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_heap_op(b));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_in_beat make_beat(t_op op, int id, logic signed [31:0] v);
        t_in_beat b;
        b.operation = op;
        b.entry_id = id[ID_W-1:0];
        b.value = v;
        return b;
    endfunction

    function automatic logic signed [31:0] rand_score();
        case ($urandom_range(5))
            0: return 32'sh7FFF_FFFF - $urandom_range(3);
            1: return 32'sh8000_0000 + $urandom_range(3);
            2: return $urandom;
            default: return $signed($urandom_range(200)) - 100;
        endcase
    endfunction

    // Output side: random stall and in-order comparison.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result %p", $realtime, o_out);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status)
                    $display("%0t status expected %0d got %0d", $realtime,
                             want.status, o_out.status);
                if (o_out.result_id !== want.result_id)
                    $display("%0t result_id expected %0d got %0d", $realtime,
                             want.result_id, o_out.result_id);
                if (o_out.score !== want.score)
                    $display("%0t score expected %0d got %0d", $realtime,
                             want.score, o_out.score);
                if (o_out.location !== want.location)
                    $display("%0t location expected %0d got %0d", $realtime,
                             want.location, o_out.location);
                if (o_out.entry_count !== want.entry_count)
                    $display("%0t entry_count expected %0d got %0d", $realtime,
                             want.entry_count, o_out.entry_count);
                if (o_out !== want) errors++;
            end
        end
    end

    int stall_left;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            stall_left <= pick_gap();
            i_out_stall <= 1'b0;
        end
    end

    // Directed table: op, id, value, and whether the expected result is typed in.
    typedef struct {
        t_op                op;
        int                 id;
        logic signed [31:0] val;
        bit                 fixed;
        t_out_beat          want;
    } t_row;

    t_row directed[$];

    task automatic add_row(t_op op, int id, logic signed [31:0] v, bit fixed,
                           t_status st = STS_OK, int rid = 0, int sc = 0,
                           int loc = 0, int cnt = 0);
        t_row row;
        row.op = op;
        row.id = id;
        row.val = v;
        row.fixed = fixed;
        row.want = '{st, rid[ID_W-1:0], sc, loc[6:0], cnt[6:0]};
        directed.push_back(row);
    endtask

    initial begin
        t_in_beat b;
        t_out_beat exp_beat;
        int n;
        int roll;
        int id;
        errors = 0;
        cycles = 0;
        sh_count = 0;
        for (int k = 0; k < 128; k++) sh_handle[k] = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(OP_REMOVE_MIN, 0, 0, 1, STS_EMPTY, 0, 0, 0, 0);
        add_row(OP_CROWN, 9, 0, 1, STS_EMPTY, 0, 0, 0, 0);
        add_row(OP_FIND, 5, 0, 1, STS_ABSENT, 5, 0, 0, 0);
        add_row(OP_INSERT, 0, 7, 1, STS_BAD_ID, 0, 0, 0, 0);
        add_row(OP_INSERT, 65, 7, 1, STS_BAD_ID, 65, 0, 0, 0);
        add_row(OP_LOCATE, 127, 0, 1, STS_BAD_ID, 127, 0, 0, 0);
        add_row(OP_INSERT, 64, 32'sh7FFF_FFFF, 1, STS_OK, 64, 32'h7FFF_FFFF, 1, 1);
        add_row(OP_INSERT, 1, 32'sh8000_0000, 1, STS_OK, 1, 32'h8000_0000, 1, 2);
        add_row(OP_INSERT, 1, 5, 1, STS_PRESENT, 1, 32'h8000_0000, 1, 2);
        add_row(OP_INSERT, 3, -1, 0);
        add_row(OP_RAISE, 64, 1, 0);
        add_row(OP_LOWER, 1, 1, 0);
        add_row(OP_RAISE, 3, 32'sh8000_0000, 0);
        add_row(OP_LOWER, 3, -20, 0);
        add_row(OP_RAISE, 2, 4, 1, STS_ABSENT, 2, 0, 0, 3);
        add_row(OP_FIND, 64, 0, 0);
        add_row(OP_LOCATE, 3, 0, 0);
        add_row(OP_RAISE, 0, 1, 1, STS_BAD_ID, 0, 0, 0, 3);
        add_row(t_op'(3'd7), 42, 99, 1, STS_OK, 0, 0, 0, 3);
        add_row(OP_REMOVE_MIN, 100, 0, 0);
        add_row(OP_INSERT, 10, 0, 0);
        add_row(OP_CROWN, 0, 0, 0);
        add_row(OP_REMOVE_MIN, 0, 0, 0);

        foreach (directed[k]) begin
            b = make_beat(directed[k].op, directed[k].id, directed[k].val);
            send_beat(b);
            if (directed[k].fixed) begin
                exp_beat = pending_results.pop_back();
                if (exp_beat !== directed[k].want) begin
                    $display("%0t row %0d expected %p predicted %p", $realtime, k,
                             directed[k].want, exp_beat);
                    errors++;
                end
                pending_results.push_back(directed[k].want);
            end
        end
        wait_drained();

        // Fill to capacity in ids order, then probe the full case and a bad id.
        for (int k = 1; k <= MAX_ENTRIES; k++)
            send_beat(make_beat(OP_INSERT, k, rand_score()));
        send_beat(make_beat(OP_INSERT, 5, 0));
        send_beat(make_beat(OP_INSERT, 0, 0));

        n = 0;
        while (n < N_RANDOM) begin
            roll = $urandom_range(99);
            id = ($urandom_range(19) == 0) ? $urandom_range(127) : $urandom_range(MAX_ENTRIES, 1);
            if (roll < 3 && sh_count > 20)
                send_beat(make_beat(OP_CROWN, $urandom_range(127), $urandom));
            else if (roll < 30)
                send_beat(make_beat(OP_INSERT, id, rand_score()));
            else if (roll < 45)
                send_beat(make_beat(OP_REMOVE_MIN, $urandom_range(127), $urandom));
            else if (roll < 58)
                send_beat(make_beat(OP_RAISE, id, rand_score()));
            else if (roll < 71)
                send_beat(make_beat(OP_LOWER, id, rand_score()));
            else if (roll < 82)
                send_beat(make_beat(OP_FIND, id, $urandom));
            else if (roll < 93)
                send_beat(make_beat(OP_LOCATE, id, $urandom));
            else if (roll < 95)
                send_beat(make_beat(t_op'(3'd7), $urandom_range(127), $urandom));
            else begin
                // Refill a run of ids so the heap stays deep.
                repeat (8)
                    send_beat(make_beat(OP_INSERT, $urandom_range(MAX_ENTRIES, 1),
                                        rand_score()));
                n += 7;
            end
            if (n == N_RANDOM / 2) wait_drained();
            n++;
        end

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
